// ===== rtl/core/ema_pkg.sv =====
// Shared constants, types and helpers for the edge message aggregator.
// Depends on nothing; every other file of the block imports it.
package ema_pkg;

   localparam int NODES        = 256;
   localparam int DIMS         = 64;
   localparam int VALUE_WIDTH  = 16;
   localparam int FRAC_BITS    = 10;
   localparam int ACTION_WIDTH = 2;
   localparam int NODE_WIDTH   = 8;
   localparam int DIM_WIDTH    = 6;
   localparam int ENTRIES      = NODES * DIMS;
   localparam int ADDR_WIDTH   = $clog2(ENTRIES);

   typedef logic [ACTION_WIDTH-1:0]       action_type;
   typedef logic [NODE_WIDTH-1:0]         node_type;
   typedef logic [DIM_WIDTH-1:0]          dim_type;
   typedef logic [ADDR_WIDTH-1:0]         addr_type;
   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   localparam action_type ACT_CLEAR = 2'd0;
   localparam action_type ACT_ACCUM = 2'd1;
   localparam action_type ACT_READ  = 2'd2;

   localparam value_type VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam value_type VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   typedef struct packed {
      value_type sum;
      value_type sum_sq;
      value_type min_v;
      value_type max_v;
   } entry_type;

   // Write port of the aggregate store
   typedef struct packed {
      logic      en;
      addr_type  addr;
      entry_type data;
   } wr_type;

   function automatic logic in_range(node_type n, dim_type d);
      return (int'(n) < NODES) && (int'(d) < DIMS);
   endfunction

   function automatic addr_type entry_addr(node_type n, dim_type d);
      return addr_type'(int'(n) * DIMS + int'(d));
   endfunction

endpackage

// ===== rtl/core/ema_req_if.sv =====
// Request channel of the edge message aggregator: valid/ready plus one item.
// Depends on ema_pkg.
interface ema_req_if;
   import ema_pkg::*;

   logic       valid;
   logic       ready;
   action_type action;
   node_type   dest_node;
   dim_type    dim_index;
   value_type  value;

   modport source (output valid, action, dest_node, dim_index, value, input ready);
   modport sink   (input valid, action, dest_node, dim_index, value, output ready);
endinterface

// ===== rtl/core/ema_rsp_if.sv =====
// Response channel of the edge message aggregator: valid/ready plus the four aggregates.
// Depends on ema_pkg.
interface ema_rsp_if;
   import ema_pkg::*;

   logic      valid;
   logic      ready;
   value_type sum_out;
   value_type sum_sq_out;
   value_type min_out;
   value_type max_out;

   modport source (output valid, sum_out, sum_sq_out, min_out, max_out, input ready);
   modport sink   (input valid, sum_out, sum_sq_out, min_out, max_out, output ready);
endinterface

// ===== rtl/core/edge_message_aggregator.sv =====
// Edge message aggregator: keeps sum, sum of squares, minimum and maximum per
// (destination node, dimension) entry in one synchronous memory.
//
// Usage:
//  - req_ch carries one item per transfer: action (clear, accumulate, read),
//    dest_node, dim_index and a signed fixed-point value.
//  - rsp_ch carries the four aggregates, one transfer for each read action;
//    clear and accumulate give no response.
//  - Every entry must be cleared before it is accumulated or read.
//  - Throughput: one item per cycle while no read waits in the modify stage.
//    Each item reads the memory on the transfer edge and writes back in the
//    next cycle; a write that hits the entry read in that cycle is forwarded,
//    so back-to-back items on the same entry run at full rate.
//  - A read answers on rsp_ch from a response register loaded as it leaves the modify stage.
//  - When rsp_ch stalls with a response held, a following read waits in the
//    modify stage and req_ch.ready drops until the response is taken.
//  - Reset (synchronous) empties the pipeline; memory contents are kept and
//    are undefined until cleared. No clearing pass is run.
// Depends on ema_pkg, ema_req_if, ema_rsp_if, ema_store, ema_update.
module edge_message_aggregator (
   input  logic      clock,
   input  logic      reset,
   ema_req_if.sink   req_ch,
   ema_rsp_if.source rsp_ch
);
   import ema_pkg::*;

   logic                     req_accept;
   logic [VALUE_WIDTH-1:0]   mag;
   logic [2*VALUE_WIDTH-1:0] prod;
   value_type                sq_in;

   logic       s1_valid_ff, s1_valid_in;
   action_type s1_action_ff;
   addr_type   s1_addr_ff;
   logic       s1_ok_ff;
   value_type  s1_value_ff;
   value_type  s1_sq_ff;
   logic       s1_go;

   entry_type  cur;
   entry_type  nxt;
   logic       upd_wr_en;
   wr_type     wr;

   logic       rsp_fire;
   logic       rsp_valid_ff, rsp_valid_in;
   entry_type  rsp_data_ff;

   assign req_accept = req_ch.valid && req_ch.ready;

   // Square of the magnitude, truncated by the fraction bits
   assign mag   = req_ch.value[VALUE_WIDTH-1] ? VALUE_WIDTH'(-req_ch.value) : req_ch.value;
   assign prod  = mag * mag;
   assign sq_in = value_type'(prod >> FRAC_BITS);

   // A read in the modify stage holds while the response register is still full and rsp_ch is not ready
   assign s1_go = !((s1_action_ff == ACT_READ) && rsp_valid_ff && !rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign s1_valid_in  = req_ch.ready ? req_accept : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_action_ff <= req_ch.action;
         s1_addr_ff   <= entry_addr(req_ch.dest_node, req_ch.dim_index);
         s1_ok_ff     <= in_range(req_ch.dest_node, req_ch.dim_index);
         s1_value_ff  <= req_ch.value;
         s1_sq_ff     <= sq_in;
      end
   end

   ema_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (entry_addr(req_ch.dest_node, req_ch.dim_index)),
      .wr      (wr),
      .rd_data (cur)
   );

   ema_update u_update (
      .valid  (s1_valid_ff),
      .ok     (s1_ok_ff),
      .action (s1_action_ff),
      .value  (s1_value_ff),
      .sq     (s1_sq_ff),
      .cur    (cur),
      .nxt    (nxt),
      .wr_en  (upd_wr_en)
   );

   always_comb begin
      wr.en   = upd_wr_en;
      wr.addr = s1_addr_ff;
      wr.data = nxt;
   end

   assign rsp_fire     = s1_valid_ff && (s1_action_ff == ACT_READ) && s1_go;
   assign rsp_valid_in = rsp_fire || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         rsp_data_ff <= s1_ok_ff ? cur : '0;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.sum_out    = rsp_data_ff.sum;
   assign rsp_ch.sum_sq_out = rsp_data_ff.sum_sq;
   assign rsp_ch.min_out    = rsp_data_ff.min_v;
   assign rsp_ch.max_out    = rsp_data_ff.max_v;

`ifndef SYNTH
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> (s1_valid_ff && $stable(s1_addr_ff)))
      else $error("stalled read left the modify stage");

   a_read_responds: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |=> rsp_valid_ff)
      else $error("read did not produce a response");

   a_write_source: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (s1_valid_ff && s1_ok_ff
                 && (s1_action_ff == ACT_CLEAR || s1_action_ff == ACT_ACCUM)))
      else $error("store written without a clear or accumulate");

   a_write_moves: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> s1_go)
      else $error("store written from a stalled stage");
`endif

endmodule

// ===== rtl/core/ema_store.sv =====
// Aggregate store: one synchronous memory holding all four aggregates of an entry,
// with a registered read and forwarding of a write that lands on the entry being read.
// Depends on ema_pkg.
module ema_store (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  ema_pkg::addr_type  rd_addr,
   input  ema_pkg::wr_type    wr,
   output ema_pkg::entry_type rd_data
);
   import ema_pkg::*;

   entry_type mem [ENTRIES];
   entry_type rdata_ff;
   entry_type fwd_data_ff;
   logic      fwd_hit_ff;
   logic      fwd_hit_in;

   // A write in the same cycle as the read returns stale data; take the new word instead
   assign fwd_hit_in = wr.en && (wr.addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rdata_ff    <= mem[rd_addr];
         fwd_data_ff <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_hit_ff <= fwd_hit_in;
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : rdata_ff;

endmodule

// ===== rtl/core/ema_update.sv =====
// Modify step of the read-modify-write: clear or accumulate one entry.
// Depends on ema_pkg.
module ema_update (
   input  logic               valid,
   input  logic               ok,
   input  ema_pkg::action_type action,
   input  ema_pkg::value_type value,
   input  ema_pkg::value_type sq,
   input  ema_pkg::entry_type cur,
   output ema_pkg::entry_type nxt,
   output logic               wr_en
);
   import ema_pkg::*;

   always_comb begin
      nxt   = cur;
      wr_en = 1'b0;
      unique case (action)
         ACT_CLEAR: begin
            nxt.sum    = '0;
            nxt.sum_sq = '0;
            nxt.min_v  = VALUE_MAX;
            nxt.max_v  = VALUE_MIN;
            wr_en      = valid && ok;
         end
         ACT_ACCUM: begin
            // both sums wrap at the value width
            nxt.sum    = value_type'(cur.sum + value);
            nxt.sum_sq = value_type'(cur.sum_sq + sq);
            if (value < cur.min_v) begin
               nxt.min_v = value;
            end
            if (value > cur.max_v) begin
               nxt.max_v = value;
            end
            wr_en = valid && ok;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

endmodule
